// ===== rtl/djb2_pkg.sv =====
// Shared types and constants for the djb2 string bucket hash core.
// Used by djb2_ctrl, djb2_dp and djb2_string_bucket_hash_core.
package djb2_pkg;

	localparam int HASH_W = 32;
	localparam int CH_W = 8;
	localparam int BKT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	localparam int HASH_SHIFT = 5;
	localparam logic [BKT_W-1:0] NUM_BKT_RST = 16'd1024;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = HASH_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BKT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE = 1'd1;

	localparam logic [CH_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [CH_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [CH_W-1:0] ASCII_CASE_BIT = 8'h20;

	typedef struct packed {
		logic hash_upd;   // fold a nonzero byte into the running hash
		logic div_start;  // terminator: capture hash, reload seed, start modulo
		logic div_step;   // one divider iteration
		logic out_load;   // move finished result into the output register
	} djb2_cmd_t;

	typedef struct packed {
		logic term;       // byte on the input is the terminator
		logic step_last;  // divider is on its final iteration
		logic out_busy;   // output register holds a result that is not taken now
	} djb2_status_t;

endpackage

// ===== rtl/djb2_ctrl.sv =====
// Controller state machine for the djb2 hash core.
// Depends on djb2_pkg; drives commands into djb2_dp.
module djb2_ctrl
	import djb2_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  djb2_status_t status,
	output djb2_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.hash_upd = accept && !status.term;
				cmd.div_start = accept && status.term;
				if (accept && status.term) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// hold the result until the output register frees up
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/djb2_dp.sv =====
// Datapath for the djb2 hash core: config registers, running hash,
// restoring modulo divider and output register. Depends on djb2_pkg.
module djb2_dp
	import djb2_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CH_W-1:0]       ch,
	input  djb2_cmd_t             cmd,
	output djb2_status_t          status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BKT_W-1:0]      bucket,
	output logic [HASH_W-1:0]     raw_hash
);

	logic [BKT_W-1:0]     num_bkt_q;
	logic                 fold_case_q;
	logic [HASH_W-1:0]    hash_q;
	logic [HASH_W-1:0]    div_hash_q;
	logic [HASH_W-1:0]    quo_q;
	logic [BKT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic [BKT_W-1:0]     bucket_q;
	logic [HASH_W-1:0]    raw_hash_q;

	logic [CH_W-1:0]      ch_fold;
	logic [HASH_W-1:0]    hash_next;
	logic [BKT_W:0]       rem_shift;
	logic [BKT_W:0]       divisor;
	logic                 rem_ge;
	logic [BKT_W-1:0]     rem_next;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bkt_q <= NUM_BKT_RST;
			fold_case_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_BKT:   num_bkt_q <= cfg_data[BKT_W-1:0];
				CFG_FOLD_CASE: fold_case_q <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		ch_fold = ch;
		if (fold_case_q && ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
			ch_fold = ch | ASCII_CASE_BIT;
		end
	end

	// hash*33 + c
	assign hash_next = (hash_q << HASH_SHIFT) + hash_q + {{(HASH_W-CH_W){1'b0}}, ch_fold};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (cmd.div_start) begin
			hash_q <= HASH_SEED;
		end else if (cmd.hash_upd) begin
			hash_q <= hash_next;
		end
	end

	// restoring divider step; remainder stays below a nonzero divisor
	assign rem_shift = {rem_q, quo_q[HASH_W-1]};
	assign divisor = {1'b0, num_bkt_q};
	assign rem_ge = (rem_shift >= divisor);
	assign rem_next = rem_ge ? BKT_W'(rem_shift - divisor) : rem_shift[BKT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_hash_q <= hash_q;
			quo_q <= hash_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_next;
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bucket_q <= (num_bkt_q == '0) ? '0 : rem_q;
			raw_hash_q <= div_hash_q;
		end
	end

	assign status.term = (ch == '0);
	assign status.step_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign status.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign bucket = bucket_q;
	assign raw_hash = raw_hash_q;

endmodule

// ===== rtl/djb2_string_bucket_hash_core.sv =====
// djb2 string bucket hash core. A nonzero byte is folded into the hash; the next byte is
// taken in the following cycle. A zero byte is accepted, then the one-bit restoring
// divider works through the 32 hash bits for hash mod the bucket total, then the
// result moves into the output register once any earlier stalled result has left
// that register. Input is stalled meanwhile. Asynchronous
// active-low reset loads hash 5381, 1024 buckets, fold_case 0, empty output.
module djb2_string_bucket_hash_core
	import djb2_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CH_W-1:0]       ch,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BKT_W-1:0]      bucket,
	output logic [HASH_W-1:0]     raw_hash
);

	djb2_cmd_t    cmd;
	djb2_status_t status;

	djb2_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	djb2_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ch        (ch),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bucket    (bucket),
		.raw_hash  (raw_hash)
	);

endmodule
